>>> hdl/urav_pkg.sv
// ----------------------------------------------------------------------------
// urav_pkg - shared types and constants of the ultrasonic range averager
// Measurement phases, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package urav_pkg;

	localparam int NUM_SAMPLES_DEF = 10;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int TICK_W = 8;
	localparam int DIST_W = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 40;

	// count to 1/16 cm: (count * 1114) >> 12
	localparam logic [10:0] CM_MULT = 11'd1114;
	localparam int CM_SHIFT = 12;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [TICK_W-1:0] SETTLE_RST = 8'd20;
	localparam logic [TICK_W-1:0] PULSE_RST = 8'd10;
	localparam logic [DIST_W-1:0] LIMIT_RST = 15'd6400;
	localparam logic [DIST_W-1:0] DEFAULT_RST = 15'd1600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETTLE  = 2'd0,
		REG_PULSE   = 2'd1,
		REG_LIMIT   = 2'd2,
		REG_DEFAULT = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_SETTLE1 = 3'd1,
		PH_PULSE  = 3'd2,
		PH_SETTLE2 = 3'd3,
		PH_WAIT   = 3'd4,
		PH_COUNT  = 3'd5
	} phase_t;

endpackage

>>> hdl/ultrasonic_range_averager.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_averager - echo ranger with moving average
// Sequences the trigger pulse, times the echo, converts to 1/16 cm and keeps
// a running-sum average over NUM_SAMPLES slots, one per measurement; only in-range results are written.
// ----------------------------------------------------------------------------
// Channel   Dir   Handshake            Contents
// s_*       in    tvalid/tready        one tick: start_req, echo
// m_*       out   tvalid/tready        one result per tick
// cfg_*     in    we (no wait)         settle, pulse, range limit, default
//
// One item per cycle sustained while the output is not stalled; each item goes
// through the input register, then the result register, once it is accepted.
// The distance of the current echo count is kept registered, so the finish
// tick only does the sum update and the reciprocal multiply for the average.
// Reset clears state, sample store and registers to their reset values.
// A stalled output holds one result while one more item waits in the input
// register; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module ultrasonic_range_averager #(
	parameter int NUM_SAMPLES = urav_pkg::NUM_SAMPLES_DEF,
	parameter int COUNT_WIDTH = urav_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [urav_pkg::IN_TDATA_W-1:0]  s_tdata,   // start_req, echo, zero pad
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [urav_pkg::OUT_TDATA_W-1:0] m_tdata,   // trig, busy_res, done_res,
	                                                    // in_range, last_distance_q4,
	                                                    // average_q4, zero pad
	input  logic                             cfg_we,
	input  logic [urav_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [urav_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import urav_pkg::*;

	localparam int SLOT_W = $clog2(NUM_SAMPLES);
	localparam int MCNT_W = $clog2(NUM_SAMPLES + 1);
	localparam int SUM_W = DIST_W + $clog2(NUM_SAMPLES);
	localparam int PROD_W = COUNT_WIDTH + 11;
	// floor(sum / N) = (sum * RECIP) >> RK, exact for all sum below 2^SUM_W
	localparam int RK = SUM_W + $clog2(NUM_SAMPLES);
	localparam int RECIP = ((1 << RK) + NUM_SAMPLES - 1) / NUM_SAMPLES;
	localparam int AVGP_W = SUM_W + RK;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SAMPLES - 1);
	localparam logic [MCNT_W-1:0] MCNT_FULL = MCNT_W'(NUM_SAMPLES);

	// configuration
	logic [TICK_W-1:0] settle_q, pulse_q;
	logic [DIST_W-1:0] limit_q, default_q;

	// pipeline
	logic valid_s1, start_s1, echo_s1;
	logic out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic adv;

	// measurement state
	phase_t phase_q, phase_d;
	logic [TICK_W-1:0] ticks_q, ticks_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [DIST_W-1:0] cdist_q, cdist_d;
	logic [DIST_W-1:0] store_q [NUM_SAMPLES];
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [MCNT_W-1:0] mcnt_q, mcnt_d;
	logic [SUM_W-1:0] sum_q, sum_d;
	logic [DIST_W-1:0] last_q, last_d;
	logic wr_en;

	// per-tick combinational terms
	phase_t ph_eff;
	logic [TICK_W-1:0] tick_inc, tick_target;
	logic trig, busy, done, acc;
	logic [AVGP_W-1:0] avg_prod;
	logic [DIST_W-1:0] avg;
	logic [PROD_W-1:0] cm_prod, cm_shift;

	assign adv = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RST;
			pulse_q <= PULSE_RST;
			limit_q <= LIMIT_RST;
			default_q <= DEFAULT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SETTLE: settle_q <= cfg_data[TICK_W-1:0];
				REG_PULSE: pulse_q <= cfg_data[TICK_W-1:0];
				REG_LIMIT: limit_q <= cfg_data[DIST_W-1:0];
				REG_DEFAULT: default_q <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			start_s1 <= s_tdata[0];
			echo_s1 <= s_tdata[1];
		end
	end

	// distance of a count, saturated to the field width
	function automatic logic [DIST_W-1:0] to_q4(input logic [PROD_W-1:0] sh);
		if (sh > PROD_W'(DIST_MAX))
			return DIST_MAX;
		return sh[DIST_W-1:0];
	endfunction

	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		count_d = count_q;
		slot_d = slot_q;
		mcnt_d = mcnt_q;
		sum_d = sum_q;
		last_d = last_q;
		wr_en = 1'b0;
		trig = 1'b0;
		busy = 1'b1;
		done = 1'b0;
		acc = 1'b0;

		ph_eff = phase_q;
		if (phase_q == PH_IDLE && start_s1) begin
			ph_eff = PH_SETTLE1;
			ticks_d = '0;
		end
		tick_inc = ticks_d + TICK_W'(1);
		tick_target = (ph_eff == PH_PULSE) ? pulse_q : settle_q;
		phase_d = ph_eff;

		case (ph_eff)
			PH_SETTLE1, PH_PULSE, PH_SETTLE2: begin
				trig = (ph_eff == PH_PULSE);
				if (tick_inc == tick_target) begin
					ticks_d = '0;
					case (ph_eff)
						PH_SETTLE1: phase_d = PH_PULSE;
						PH_PULSE: phase_d = PH_SETTLE2;
						default: phase_d = PH_WAIT;
					endcase
				end else begin
					ticks_d = tick_inc;
				end
			end
			PH_WAIT: begin
				if (echo_s1) begin
					count_d = COUNT_WIDTH'(1);
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (echo_s1) begin
					if (count_q != '1)
						count_d = count_q + COUNT_WIDTH'(1);
				end else begin
					done = 1'b1;
					busy = 1'b0;
					phase_d = PH_IDLE;
					ticks_d = '0;
					last_d = cdist_q;
					slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
					if (mcnt_q < MCNT_FULL)
						mcnt_d = mcnt_q + MCNT_W'(1);
					if (cdist_q < limit_q) begin
						acc = 1'b1;
						wr_en = 1'b1;
						sum_d = sum_q - SUM_W'(store_q[slot_d]) + SUM_W'(cdist_q);
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				busy = 1'b0;
			end
		endcase

		// track the distance of the echo count as it grows
		cm_prod = PROD_W'(count_d) * PROD_W'(CM_MULT);
		cm_shift = cm_prod >> CM_SHIFT;
		cdist_d = to_q4(cm_shift);

		avg_prod = AVGP_W'(sum_d) * AVGP_W'(RECIP);
		avg = (mcnt_d >= MCNT_FULL) ? avg_prod[RK +: DIST_W] : default_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			count_q <= '0;
			cdist_q <= '0;
			slot_q <= '0;
			mcnt_q <= '0;
			sum_q <= '0;
			last_q <= '0;
			for (int i = 0; i < NUM_SAMPLES; i++)
				store_q[i] <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			count_q <= count_d;
			cdist_q <= cdist_d;
			slot_q <= slot_d;
			mcnt_q <= mcnt_d;
			sum_q <= sum_d;
			last_q <= last_d;
			if (wr_en)
				store_q[slot_d] <= cdist_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_data_q <= {6'd0, avg, last_d, acc, done, busy, trig};
	end

endmodule

>>> verif/tb_ultrasonic_range_averager.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_averager - self-checking bench for the range averager
// Streams echo ticks into the block, mirrors the trigger sequencer, echo
// counter and running-sum average in a local model, and compares every
// result item field by field. Covers short and wrapped tick counts, range
// rejection, the averaging window, random traffic and back-pressure.
// ----------------------------------------------------------------------------
module tb_ultrasonic_range_averager;
	import urav_pkg::*;

	localparam int NUM_SAMPLES = NUM_SAMPLES_DEF;
	localparam int COUNT_WIDTH = COUNT_WIDTH_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic              trig;
		logic              busy;
		logic              done;
		logic              in_range;
		logic [DIST_W-1:0] last_dist;
		logic [DIST_W-1:0] avg;
	} tick_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_SETTLE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// local copy of the block's registers and state
	logic [TICK_W-1:0]      cfg_settle = SETTLE_RST;
	logic [TICK_W-1:0]      cfg_pulse = PULSE_RST;
	logic [DIST_W-1:0]      cfg_limit = LIMIT_RST;
	logic [DIST_W-1:0]      cfg_default = DEFAULT_RST;
	phase_t                 ph = PH_IDLE;
	logic [TICK_W-1:0]      ph_ticks = '0;
	logic [COUNT_WIDTH-1:0] echo_cnt = '0;
	logic [DIST_W-1:0]      dist_store [NUM_SAMPLES];
	int                     slot = 0;
	int                     meas_cnt = 0;
	logic [17:0]            dist_sum = '0;
	logic [DIST_W-1:0]      last_dist = '0;

	tick_result_t           expected_ticks [$];
	int                     error_count = 0;
	int                     tick_count = 0;
	int                     idle_cycles = 0;
	int                     tx_gap_pct = 0;
	int                     rx_gap_pct = 0;
	bit                     hold_req = 1'b0;

	ultrasonic_range_averager #(
		.NUM_SAMPLES(NUM_SAMPLES),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < NUM_SAMPLES; i++) dist_store[i] = '0;
	end

	// count one tick of the current phase; true when the phase is over
	function automatic bit phase_elapsed(input logic [TICK_W-1:0] target);
		ph_ticks = ph_ticks + 1'b1;
		if (ph_ticks == target) begin
			ph_ticks = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic tick_result_t predict_tick(input bit start_req, input bit echo);
		tick_result_t r;
		logic [31:0]  prod;
		logic [DIST_W-1:0] d;
		r = '0;
		r.busy = 1'b1;
		if (ph == PH_IDLE && start_req) begin
			ph = PH_SETTLE1;
			ph_ticks = '0;
		end
		case (ph)
			PH_SETTLE1: begin
				if (phase_elapsed(cfg_settle)) ph = PH_PULSE;
			end
			PH_PULSE: begin
				r.trig = 1'b1;
				if (phase_elapsed(cfg_pulse)) ph = PH_SETTLE2;
			end
			PH_SETTLE2: begin
				if (phase_elapsed(cfg_settle)) ph = PH_WAIT;
			end
			PH_WAIT: begin
				if (echo) begin
					echo_cnt = COUNT_WIDTH'(1);
					ph = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (echo) begin
					if (echo_cnt != '1) echo_cnt = echo_cnt + 1'b1;
				end else begin
					prod = 32'(echo_cnt) * 32'd1114;
					prod = prod >> 12;
					d = (prod > 32'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
					r.done = 1'b1;
					r.busy = 1'b0;
					ph = PH_IDLE;
					ph_ticks = '0;
					last_dist = d;
					slot = (slot + 1) % NUM_SAMPLES;
					if (meas_cnt < NUM_SAMPLES) meas_cnt++;
					if (d < cfg_limit) begin
						r.in_range = 1'b1;
						dist_sum = dist_sum - dist_store[slot] + d;
						dist_store[slot] = d;
					end
				end
			end
			default: begin
				ph = PH_IDLE;
				r.busy = 1'b0;
			end
		endcase
		r.last_dist = last_dist;
		r.avg = (meas_cnt >= NUM_SAMPLES) ? DIST_W'(dist_sum / NUM_SAMPLES) : cfg_default;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		$display("MISMATCH tick result %s: got %0d expected %0d", what, got, want);
	endtask

	// offer one tick, with an occasional gap ahead of it; predict on accept
	task automatic send_tick(input bit start_req, input bit echo);
		if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, echo, start_req};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_ticks.push_back(predict_tick(start_req, echo));
		tick_count++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic load_config(input logic [TICK_W-1:0] settle, input logic [TICK_W-1:0] pulse,
			input logic [DIST_W-1:0] limit, input logic [DIST_W-1:0] dflt);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_SETTLE;
		cfg_data <= CFG_DATA_W'(settle);
		@(posedge clk);
		cfg_index <= REG_PULSE;
		cfg_data <= CFG_DATA_W'(pulse);
		@(posedge clk);
		cfg_index <= REG_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_index <= REG_DEFAULT;
		cfg_data <= dflt;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_settle = settle;
		cfg_pulse = pulse;
		cfg_limit = limit;
		cfg_default = dflt;
	endtask

	// one full ranging cycle: start, ride out the trigger, then the echo
	task automatic run_measurement(input int wait_lo, input int high_len);
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		while (ph != PH_WAIT) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		repeat (wait_lo) send_tick(1'($urandom_range(0, 1)), 1'b0);
		repeat (high_len) send_tick(1'($urandom_range(0, 1)), 1'b1);
		send_tick(1'($urandom_range(0, 1)), 1'b0);
	endtask

	task automatic idle_noise(input int n);
		repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)));
	endtask

	task automatic test_reset_values();
		tx_gap_pct = 10;
		rx_gap_pct = 10;
		idle_noise(4);
		run_measurement(3, 5);
		// echo stays low for a long while before it rises
		run_measurement(20, 2);
	endtask

	task automatic test_trigger_timing();
		tx_gap_pct = 0;
		rx_gap_pct = 0;
		load_config(8'd1, 8'd1, 15'd17824, 15'd0);
		run_measurement(0, 1);
		// a zero count is a full wrap of the tick counter
		load_config(8'd1, 8'd0, 15'd0, 15'd17823);
		run_measurement(2, 3);
	endtask

	task automatic test_range_limits();
		tx_gap_pct = 15;
		rx_gap_pct = 15;
		load_config(8'd2, 8'd1, 15'd16, 15'd17823);
		run_measurement(1, 58);
		run_measurement(1, 60);
		load_config(8'd1, 8'd2, 15'd0, 15'd0);
		run_measurement(0, 3);
	endtask

	task automatic test_average_window();
		tx_gap_pct = 20;
		rx_gap_pct = 20;
		load_config(8'd1, 8'd1, 15'd5, 15'd17823);
		for (int i = 0; i < 10; i++) begin
			idle_noise($urandom_range(0, 2));
			run_measurement($urandom_range(0, 3), $urandom_range(1, 24));
		end
	endtask

	task automatic random_phase(input int n_ticks);
		int stop_at;
		int pick;
		logic [DIST_W-1:0] limit;
		stop_at = tick_count + n_ticks;
		pick = $urandom_range(0, 9);
		limit = (pick == 0) ? 15'd0 : (pick == 1) ? 15'd17824 : 15'($urandom_range(0, 24));
		load_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)), limit,
			15'($urandom_range(0, 17823)));
		while (tick_count < stop_at) begin
			idle_noise($urandom_range(0, 4));
			if ($urandom_range(0, 9) == 0)
				run_measurement($urandom_range(0, 20), $urandom_range(61, 120));
			else
				run_measurement($urandom_range(0, 6), $urandom_range(1, 30));
		end
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 3; p++) begin
			tx_gap_pct = $urandom_range(5, 40);
			rx_gap_pct = $urandom_range(5, 40);
			random_phase(30);
		end
	endtask

	task automatic test_backpressure();
		tx_gap_pct = 0;
		rx_gap_pct = 10;
		drain_results();
		hold_req = 1'b1;
		random_phase(30);
	endtask

	task automatic test_full_rate();
		tx_gap_pct = 0;
		rx_gap_pct = 0;
		random_phase(30);
	endtask

	// receiver: random stall bursts, or one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		tick_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_ticks.size() == 0) begin
				report_mismatch("with nothing pending", longint'(m_tdata), 0);
			end else begin
				want = expected_ticks.pop_front();
				if (m_tdata[0] !== want.trig)
					report_mismatch("trig", m_tdata[0], want.trig);
				if (m_tdata[1] !== want.busy)
					report_mismatch("busy_res", m_tdata[1], want.busy);
				if (m_tdata[2] !== want.done)
					report_mismatch("done_res", m_tdata[2], want.done);
				if (m_tdata[3] !== want.in_range)
					report_mismatch("in_range", m_tdata[3], want.in_range);
				if (m_tdata[18:4] !== want.last_dist)
					report_mismatch("last_distance_q4", m_tdata[18:4], want.last_dist);
				if (m_tdata[33:19] !== want.avg)
					report_mismatch("average_q4", m_tdata[33:19], want.avg);
				if (m_tdata[39:34] !== '0)
					report_mismatch("pad bits", m_tdata[39:34], 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("ultrasonic_range_averager test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		test_reset_values();
		test_trigger_timing();
		test_range_limits();
		test_average_window();
		test_random_traffic();
		test_backpressure();
		test_full_rate();
		drain_results();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("ultrasonic_range_averager test passed");
		else
			$display("ultrasonic_range_averager test failed");
		$finish;
	end

endmodule
